FILE: hw/rtl/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants for the face to strip stitcher.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam int unsigned FTS_IDX_W       = 15;
  localparam int unsigned FTS_CNT_W       = 32;
  localparam int unsigned FTS_MAX_OUT     = 6;
  localparam int unsigned FTS_NUM_W       = 3;
  localparam int unsigned FTS_QUEUE_DEPTH = 2;

  // Corner counts per face type, bridge length
  localparam logic [FTS_NUM_W-1:0] FTS_QUAD_CORNERS = 3'd4;
  localparam logic [FTS_NUM_W-1:0] FTS_TRI_CORNERS  = 3'd3;
  localparam logic [FTS_NUM_W-1:0] FTS_BRIDGE_LEN   = 3'd2;

  // Triangles added per face type
  localparam logic [FTS_CNT_W-1:0] FTS_QUAD_TRIS = 32'd2;
  localparam logic [FTS_CNT_W-1:0] FTS_TRI_TRIS  = 32'd1;

  typedef logic [FTS_IDX_W-1:0] idx_t;

  typedef struct packed {
    logic restart_strip;
    logic is_quad;
    idx_t corner_a;
    idx_t corner_b;
    idx_t corner_c;
    idx_t corner_d;
  } in_word_t;

  typedef struct packed {
    idx_t                 strip_index;
    logic                 last_of_run;
    logic [FTS_CNT_W-1:0] triangle_total;
  } out_word_t;

  // One classified face: ordered indices, how many, and the count to report
  typedef struct packed {
    idx_t [FTS_MAX_OUT-1:0] idx;
    logic [FTS_NUM_W-1:0]   num;
    logic [FTS_CNT_W-1:0]   total;
  } job_t;

endpackage

FILE: hw/rtl/face_to_strip_stitcher_core.sv
// The first index of a face passes through the queue, the current-job register
// and the output register. One index word per cycle while out_stall_i is low;
// a face gives 3 to 6 words (3 or 4 corners plus 2 bridge indices if bridged).
// A queue of QueueDepth jobs lets intake run ahead of the output side.
// Reset (async, active low) clears strip state, triangle count and queue.
// ----------------------------------------------------------------------------
// face_to_strip_stitcher_core
// Turns triangle and quad faces into triangle strip indices with bridges.
// ----------------------------------------------------------------------------
module face_to_strip_stitcher_core import fts_pkg::*; #(
  parameter int unsigned QueueDepth = FTS_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic push, full, job_valid, pop;
  job_t push_job, head_job;

  // Classify faces
  fts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  // Decouple front and back
  fts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .valid_o    (job_valid),
    .head_o     (head_job),
    .pop_i      (pop)
  );

  // Emit indices
  fts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: hw/rtl/fts_front.sv
// ----------------------------------------------------------------------------
// fts_front
// Accepts faces, orders corners, adds the bridge and updates strip state.
// ----------------------------------------------------------------------------
module fts_front import fts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  output logic     push_o,
  output job_t     push_job_o,
  input  logic     full_i
);

  idx_t                 prev_q;
  logic                 have_q;
  logic                 rev_q;
  logic [FTS_CNT_W-1:0] count_q;

  logic                 rev;
  logic                 bridge;
  idx_t [3:0]           corners;
  logic [FTS_CNT_W-1:0] add;
  logic [FTS_CNT_W:0]   sum;
  logic [FTS_CNT_W-1:0] count_d;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the face against the current strip state
  always_comb begin
    rev    = in_word_i.restart_strip ? 1'b0 : rev_q;
    bridge = in_word_i.restart_strip ? 1'b0 : have_q;

    corners[0] = in_word_i.corner_a;
    if (in_word_i.is_quad) begin
      corners[1] = rev ? in_word_i.corner_b : in_word_i.corner_d;
      corners[2] = rev ? in_word_i.corner_d : in_word_i.corner_b;
      corners[3] = in_word_i.corner_c;
    end else begin
      corners[1] = rev ? in_word_i.corner_b : in_word_i.corner_c;
      corners[2] = rev ? in_word_i.corner_c : in_word_i.corner_b;
      corners[3] = '0;
    end

    add     = in_word_i.is_quad ? FTS_QUAD_TRIS : FTS_TRI_TRIS;
    sum     = {1'b0, count_q} + {1'b0, add};
    count_d = sum[FTS_CNT_W] ? '1 : sum[FTS_CNT_W-1:0];

    push_job_o.idx = '0;
    if (bridge) begin
      push_job_o.idx[0] = prev_q;
      push_job_o.idx[1] = in_word_i.corner_a;
      for (int i = 0; i < 4; i++) begin
        push_job_o.idx[i+2] = corners[i];
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        push_job_o.idx[i] = corners[i];
      end
    end
    push_job_o.num   = (in_word_i.is_quad ? FTS_QUAD_CORNERS : FTS_TRI_CORNERS)
                       + (bridge ? FTS_BRIDGE_LEN : '0);
    push_job_o.total = count_d;
  end

  // Advance strip state on each accepted word; keep the last corner emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      have_q  <= 1'b0;
      rev_q   <= 1'b0;
      count_q <= '0;
    end else if (push_o) begin
      prev_q  <= in_word_i.is_quad ? corners[3] : corners[2];
      have_q  <= 1'b1;
      rev_q   <= in_word_i.is_quad ? rev : !rev;
      count_q <= count_d;
    end
  end

endmodule

FILE: hw/rtl/fts_queue.sv
// ----------------------------------------------------------------------------
// fts_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module fts_queue import fts_pkg::*; #(
  parameter int unsigned Depth = FTS_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count beyond depth");
`endif

endmodule

FILE: hw/rtl/fts_back.sv
// ----------------------------------------------------------------------------
// fts_back
// Walks one job per face and emits its indices through an output register.
// ----------------------------------------------------------------------------
module fts_back import fts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  job_t                 cur_q;
  logic                 cur_valid_q;
  logic [FTS_NUM_W-1:0] step_q;
  logic                 out_valid_q;
  out_word_t            out_q;

  logic advance;
  logic is_last;
  logic load;

  assign advance = cur_valid_q && (!out_valid_q || !out_stall_i);
  assign is_last = (step_q == cur_q.num - 1'b1);
  assign load    = !cur_valid_q || (advance && is_last);
  assign pop_o   = load && job_valid_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Hold the current job
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  // Step through the job and fill the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= job_valid_i;
        step_q      <= '0;
      end else if (advance) begin
        step_q <= step_q + 1'b1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Word payload needs no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.strip_index    <= cur_q.idx[step_q];
      out_q.last_of_run    <= is_last;
      out_q.triangle_total <= cur_q.total;
    end
  end

`ifndef SYNTHESIS
  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (step_q < cur_q.num)) else $error("step past job length");
  a_num_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_q.num >= FTS_TRI_CORNERS && cur_q.num <= 3'(FTS_MAX_OUT)))
    else $error("job length out of range");
  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_q.last_of_run) |=>
      (out_valid_q && out_q.triangle_total == $past(out_q.triangle_total)))
    else $error("face run broken or total changed mid-run");
`endif

endmodule

FILE: tb/sv/face_to_strip_stitcher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_to_strip_stitcher_core_tb
// Self-checking bench for the strip stitcher. A queue of faces feeds a
// valid/stall driver. Every face that is taken is run through a local
// stitching predictor, and the index words it should cause are queued. The
// monitor checks each output word field by field against the oldest of them.
// ----------------------------------------------------------------------------
module face_to_strip_stitcher_core_tb;
  import fts_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned RANDOM_FACES   = 220;
  localparam int unsigned MAX_REPORTS    = 60;
  localparam idx_t        IDX_MAX        = {FTS_IDX_W{1'b1}};
  localparam logic [FTS_CNT_W-1:0] CNT_MAX = {FTS_CNT_W{1'b1}};

  typedef struct {
    in_word_t word;
    bit       drain;
  } face_item_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  face_to_strip_stitcher_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Pending faces and the strip words they are predicted to produce
  face_item_t face_q[$];
  out_word_t  strip_word_q[$];

  // Predictor copy of the strip state
  idx_t                 prev_idx;
  bit                   have_prev;
  bit                   rev_next;
  logic [FTS_CNT_W-1:0] tri_count;

  int unsigned error_cnt    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned faces_taken  = 0;
  int unsigned quads_taken  = 0;
  int unsigned restarts     = 0;
  int unsigned bridges      = 0;
  int unsigned words_seen   = 0;
  int unsigned faces_sent   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  bit          stall_now    = 1'b0;
  logic        in_took      = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    if (error_cnt < MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    error_cnt++;
  endtask

  task automatic push_strip_word(input idx_t idx, input logic last);
    out_word_t w;
    w.strip_index    = idx;
    w.last_of_run    = last;
    w.triangle_total = tri_count;
    strip_word_q.push_back(w);
  endtask

  // Predict the strip words for one accepted face and advance the strip state
  task automatic stitch_face(input in_word_t f);
    idx_t                 seq [FTS_QUAD_CORNERS];
    int unsigned          ncorner;
    logic [FTS_CNT_W-1:0] add;
    int unsigned          i;
    if (f.restart_strip) begin
      have_prev = 1'b0;
      rev_next  = 1'b0;
      restarts++;
    end
    seq[0] = f.corner_a;
    seq[3] = '0;
    if (f.is_quad) begin
      seq[1]  = rev_next ? f.corner_b : f.corner_d;
      seq[2]  = rev_next ? f.corner_d : f.corner_b;
      seq[3]  = f.corner_c;
      ncorner = FTS_QUAD_CORNERS;
      add     = FTS_QUAD_TRIS;
      quads_taken++;
    end else begin
      seq[1]   = rev_next ? f.corner_b : f.corner_c;
      seq[2]   = rev_next ? f.corner_c : f.corner_b;
      ncorner  = FTS_TRI_CORNERS;
      add      = FTS_TRI_TRIS;
      rev_next = !rev_next;
    end
    // Saturate the running triangle count
    if (tri_count > CNT_MAX - add) tri_count = CNT_MAX;
    else tri_count = tri_count + add;
    // Bridge back to the previous index with a degenerate pair
    if (have_prev) begin
      push_strip_word(prev_idx, 1'b0);
      push_strip_word(f.corner_a, 1'b0);
      bridges++;
    end
    for (i = 0; i < ncorner; i++) begin
      push_strip_word(seq[i], (i == ncorner - 1));
    end
    prev_idx  = seq[ncorner-1];
    have_prev = 1'b1;
    faces_taken++;
  endtask

  task automatic add_face(input bit rs, input bit quad, input idx_t a, input idx_t b,
                          input idx_t c, input idx_t d, input bit drain);
    face_item_t it;
    it.word.restart_strip = rs;
    it.word.is_quad       = quad;
    it.word.corner_a      = a;
    it.word.corner_b      = b;
    it.word.corner_c      = c;
    it.word.corner_d      = d;
    it.drain              = drain;
    face_q.push_back(it);
  endtask

  function automatic idx_t rand_corner();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return IDX_MAX;
    return idx_t'($urandom_range(0, IDX_MAX));
  endfunction

  // Mostly short gaps, a few long ones, none during quiet stretches
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: present faces at the falling edge, hold them until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (face_q.size() > 0 &&
                     !(face_q[0].drain && strip_word_q.size() != 0)) begin
          in_word_i  <= face_q[0].word;
          in_valid_i <= 1'b1;
          face_q.pop_front();
          faces_sent++;
          gap_left = pick_gap(((faces_sent / 32) % 4) == 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall in runs of random length, with stretches of no stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        if (((cycle_cnt / 300) % 4) == 1) begin
          stall_now  = 1'b0;
          stall_left = 8;
        end else if ($urandom_range(0, 99) < 35) begin
          stall_now  = 1'b1;
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                   : $urandom_range(1, 3);
        end else begin
          stall_now  = 1'b0;
          stall_left = $urandom_range(1, 6);
        end
      end
      out_stall_i <= stall_now;
      stall_left--;
    end
  end

  // Monitor: predict taken faces, check taken words, track activity
  always @(posedge clk_i) begin
    bit        in_fire;
    bit        out_fire;
    out_word_t want;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    in_took <= in_fire;
    if (rst_ni) cycle_cnt++;
    if (in_fire) stitch_face(in_word_i);
    if (out_fire) begin
      words_seen++;
      if (strip_word_q.size() == 0) begin
        report_error($sformatf("unexpected word idx=%0d last=%0b total=%0d",
                     out_word_o.strip_index, out_word_o.last_of_run,
                     out_word_o.triangle_total));
      end else begin
        want = strip_word_q.pop_front();
        if (out_word_o.strip_index !== want.strip_index)
          report_error($sformatf("word %0d strip_index got %0d want %0d", words_seen,
                       out_word_o.strip_index, want.strip_index));
        if (out_word_o.last_of_run !== want.last_of_run)
          report_error($sformatf("word %0d last_of_run got %0b want %0b", words_seen,
                       out_word_o.last_of_run, want.last_of_run));
        if (out_word_o.triangle_total !== want.triangle_total)
          report_error($sformatf("word %0d triangle_total got %0d want %0d", words_seen,
                       out_word_o.triangle_total, want.triangle_total));
      end
    end
    if (in_fire || out_fire || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned n;
    int unsigned run_len;
    int unsigned k;
    bit          rs;
    prev_idx  = '0;
    have_prev = 1'b0;
    rev_next  = 1'b0;
    tri_count = '0;

    // Directed: first face without restart, then every corner order and bridge
    add_face(1'b0, 1'b0, 15'd0, 15'd1, 15'd2, IDX_MAX, 1'b0);
    add_face(1'b0, 1'b0, 15'd3, 15'd4, 15'd5, 15'd6, 1'b0);
    add_face(1'b0, 1'b1, 15'd7, 15'd8, 15'd9, 15'd10, 1'b0);
    add_face(1'b0, 1'b0, 15'd11, 15'd12, 15'd13, 15'd14, 1'b0);
    add_face(1'b0, 1'b1, 15'd15, 15'd16, 15'd17, 15'd18, 1'b0);
    add_face(1'b0, 1'b1, 15'd19, 15'd20, 15'd21, 15'd22, 1'b0);
    add_face(1'b0, 1'b0, 15'd23, 15'd24, 15'd25, 15'd26, 1'b0);
    // Restart while the reverse flag is set and a previous index exists
    add_face(1'b0, 1'b0, 15'd27, 15'd28, 15'd29, 15'd30, 1'b0);
    add_face(1'b1, 1'b1, IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX, 1'b0);
    add_face(1'b1, 1'b0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0);
    add_face(1'b0, 1'b1, 15'h5555, 15'h2AAA, 15'h5555, 15'h2AAA, 1'b0);
    add_face(1'b0, 1'b0, 15'h2AAA, 15'h5555, 15'h2AAA, 15'h5555, 1'b0);
    add_face(1'b0, 1'b1, IDX_MAX, 15'd0, IDX_MAX, 15'd0, 1'b1);
    add_face(1'b1, 1'b0, 15'd0, IDX_MAX, 15'd0, IDX_MAX, 1'b0);
    add_face(1'b0, 1'b0, 15'd100, 15'd200, 15'd300, 15'd400, 1'b1);
    add_face(1'b0, 1'b1, 15'd1, 15'd2, 15'd4, 15'd8, 1'b0);

    // Random strips: runs of faces, mostly opened by a restart
    n = 0;
    while (n < RANDOM_FACES) begin
      run_len = $urandom_range(1, 12);
      for (k = 0; k < run_len; k++) begin
        if (k == 0) rs = ($urandom_range(0, 9) != 0);
        else rs = ($urandom_range(0, 32) == 0);
        add_face(rs, $urandom_range(0, 1), rand_corner(), rand_corner(),
                 rand_corner(), rand_corner(), (n == 110) || ($urandom_range(0, 49) == 0));
        n++;
      end
    end

    // Hold reset, then release at a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Run until every face is taken and every word has come back
    @(posedge clk_i);
    while ((face_q.size() != 0 || in_valid_i || strip_word_q.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      report_error($sformatf("watchdog: no traffic for %0d cycles, %0d words pending",
                   WATCHDOG_LIMIT, strip_word_q.size()));
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (strip_word_q.size() != 0)
        report_error($sformatf("%0d strip words never arrived", strip_word_q.size()));
    end

    $display("Covered %0d faces (%0d quads, %0d restarts, %0d bridged), %0d words checked",
             faces_taken, quads_taken, restarts, bridges, words_seen);
    $display("Final triangle total %0d, mismatches %0d", tri_count, error_cnt);
    if (error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/fts_pkg.sv
hw/rtl/fts_front.sv
hw/rtl/fts_queue.sv
hw/rtl/fts_back.sv
hw/rtl/face_to_strip_stitcher_core.sv
tb/sv/face_to_strip_stitcher_core_tb.sv
